/* hdl/running_block_average_stats_macros.svh */
// assertion macros for the running block average statistics block
// used by the top level only, no other dependencies
`ifndef RUNNING_BLOCK_AVERAGE_STATS_MACROS_SVH
`define RUNNING_BLOCK_AVERAGE_STATS_MACROS_SVH

// same-cycle implication, disabled during reset
`define RBAS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define RBAS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/rbas_pkg.sv */
// shared types and constants of the running block average statistics block
// no dependencies
package rbas_pkg;

   // payload types
   typedef logic signed [31:0] q16_type;
   typedef logic        [31:0] uq16_type;
   typedef logic        [25:0] trials_type;
   typedef logic        [15:0] blen_type;

   // accumulator and divider widths
   localparam int SUM_W      = 42;
   localparam int DIV_W      = 64;
   localparam int DIV_STEPS  = 4;
   localparam int SQRT_W     = 64;

   localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
   localparam trials_type       TRIALS_MAX   = 26'h3FF_FFFF;
   localparam logic [31:0]      MEAN_POS_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0]      MEAN_NEG_MAG = 32'h8000_0000;
   localparam logic [SQRT_W-1:0] SQRT_BIT0   = 64'h4000_0000_0000_0000;

   // controller to datapath commands
   typedef struct packed {
      logic load;
      logic square;
      logic accum;
      logic mean_go;
      logic mean_take;
      logic msq_go;
      logic var_calc;
      logic vdiv_go;
      logic sqrt_go;
      logic unc_take;
      logic out_load;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic div_idle;
      logic sqrt_idle;
      logic multi;
   } status_type;

   // one result item
   typedef struct packed {
      q16_type    running_mean;
      uq16_type   uncertainty;
      trials_type trials_so_far;
      logic       overflow;
   } result_type;

endpackage

/* hdl/rbas_ifs.sv */
// valid/ready channel interfaces: block means in, statistics out, block length write
// depends on rbas_pkg
interface rbas_req_if;
   logic              valid;
   logic              ready;
   rbas_pkg::q16_type block_mean;
   logic              restart;

   modport source (output valid, block_mean, restart, input ready);
   modport sink   (input valid, block_mean, restart, output ready);
endinterface

interface rbas_rsp_if;
   logic                 valid;
   logic                 ready;
   rbas_pkg::q16_type    running_mean;
   rbas_pkg::uq16_type   uncertainty;
   rbas_pkg::trials_type trials_so_far;
   logic                 overflow;

   modport source (output valid, running_mean, uncertainty, trials_so_far, overflow,
                   input ready);
   modport sink   (input valid, running_mean, uncertainty, trials_so_far, overflow,
                   output ready);
endinterface

interface rbas_csr_if;
   logic               valid;
   logic               ready;
   rbas_pkg::blen_type block_length;

   modport source (output valid, block_length, input ready);
   modport sink   (input valid, block_length, output ready);
endinterface

/* hdl/running_block_average_stats.sv */
// Running block-average statistics. Each transfer on req_chan brings one block mean
// (signed Q16.16) and a restart flag; each produces one transfer on rsp_chan with the
// running mean, its standard error (unsigned Q16.16, zero for a single block), the
// trials so far (block count times block_length, saturated) and a sticky overflow flag.
// The time per item is set by the shared divider, which resolves four quotient bits per cycle
// (one 64-bit division per item when one block is held, three otherwise), and by the square
// root unit, which resolves one result bit per cycle and runs only when more than one block
// is held. The next item is taken as soon as the previous result sits in the output register.
// block_length is written on csr_chan, which is always ready; the user must write it only while
// the block is idle, as the block itself does not enforce this.
// depends on rbas_pkg, rbas_ifs, rbas_ctrl, rbas_datapath, macros header
`include "running_block_average_stats_macros.svh"

module running_block_average_stats #(
   parameter int MAX_BLOCKS = 1024
) (
   input  logic       clock,
   input  logic       reset,
   rbas_req_if.sink   req_chan,
   rbas_rsp_if.source rsp_chan,
   rbas_csr_if.sink   csr_chan
);

   rbas_pkg::cmd_type    cmd;
   rbas_pkg::status_type status;
   rbas_pkg::result_type result;

   // configuration writes are taken every cycle
   assign csr_chan.ready = 1'b1;

   rbas_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   rbas_datapath #(
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .block_mean (req_chan.block_mean),
      .restart    (req_chan.restart),
      .csr_write  (csr_chan.valid),
      .csr_data   (csr_chan.block_length),
      .result     (result)
   );

   // result register onto the output channel
   assign rsp_chan.running_mean  = result.running_mean;
   assign rsp_chan.uncertainty   = result.uncertainty;
   assign rsp_chan.trials_so_far = result.trials_so_far;
   assign rsp_chan.overflow      = result.overflow;

   // the divider is never restarted while a division runs
   `RBAS_ASSERT_NOW(a_div_free, clock, reset, (cmd.mean_go || cmd.msq_go || cmd.vdiv_go), status.div_idle, "divider started while busy")
   // the root unit is never restarted while it runs
   `RBAS_ASSERT_NOW(a_sqrt_free, clock, reset, cmd.sqrt_go, status.sqrt_idle, "square root started while busy")
   // an accepted item blocks the input for at least the next cycle
   `RBAS_ASSERT_NEXT(a_one_item, clock, reset, (req_chan.valid && req_chan.ready), !req_chan.ready, "input ready right after a transfer")

endmodule

/* hdl/rbas_div.sv */
// iterative unsigned divider, 64-bit dividend, a few quotient bits per cycle
// depends on rbas_pkg
module rbas_div #(
   parameter int NW = 11
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [rbas_pkg::DIV_W-1:0] dividend,
   input  logic [NW-1:0]              divisor,
   output logic                       busy,
   output logic [rbas_pkg::DIV_W-1:0] quotient
);

   localparam int CYCLES = rbas_pkg::DIV_W / rbas_pkg::DIV_STEPS;
   localparam int CNT_W  = (CYCLES > 1) ? $clog2(CYCLES) : 1;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CYCLES - 1);

   logic                       busy_ff, busy_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic [rbas_pkg::DIV_W-1:0] dvd_ff, dvd_in, dvd_step;
   logic [NW-1:0]              rem_ff, rem_in, rem_step;
   logic [NW-1:0]              dsr_ff, dsr_in;
   logic [NW:0]                rext;

   // restoring long division, quotient shifts into the dividend register
   always_comb begin
      rem_step = rem_ff;
      dvd_step = dvd_ff;
      rext     = '0;
      for (int i = 0; i < rbas_pkg::DIV_STEPS; i++) begin
         rext     = {rem_step, dvd_step[rbas_pkg::DIV_W-1]};
         dvd_step = {dvd_step[rbas_pkg::DIV_W-2:0], 1'b0};
         if (rext >= {1'b0, dsr_ff}) begin
            rext        = rext - {1'b0, dsr_ff};
            dvd_step[0] = 1'b1;
         end
         rem_step = rext[NW-1:0];
      end
   end

   // load on start, step while busy
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_LAST;
         dvd_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         dvd_in = dvd_step;
         rem_in = rem_step;
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign busy     = busy_ff;
   assign quotient = dvd_ff;

endmodule

/* hdl/rbas_sqrt.sv */
// iterative integer square root of a 64-bit value, one result bit per cycle
// depends on rbas_pkg
module rbas_sqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [rbas_pkg::SQRT_W-1:0] operand,
   output logic                        busy,
   output logic [31:0]                 root
);

   logic                        busy_ff, busy_in;
   logic [rbas_pkg::SQRT_W-1:0] v_ff, v_in;
   logic [rbas_pkg::SQRT_W-1:0] res_ff, res_in;
   logic [rbas_pkg::SQRT_W-1:0] bit_ff, bit_in;
   logic [rbas_pkg::SQRT_W-1:0] trial;

   assign trial = res_ff + bit_ff;

   // digit-by-digit root, trial subtract of res + bit
   always_comb begin
      busy_in = busy_ff;
      v_in    = v_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      if (start) begin
         busy_in = 1'b1;
         v_in    = operand;
         res_in  = '0;
         bit_in  = rbas_pkg::SQRT_BIT0;
      end else if (busy_ff) begin
         if (v_ff >= trial) begin
            v_in   = v_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff[0]) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      v_ff   <= v_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign busy = busy_ff;
   assign root = res_ff[31:0];

endmodule

/* hdl/rbas_datapath.sv */
// datapath: accumulators, mean, variance, shared divider and square root
// depends on rbas_pkg, rbas_div, rbas_sqrt
module rbas_datapath #(
   parameter int MAX_BLOCKS = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  rbas_pkg::cmd_type    cmd,
   output rbas_pkg::status_type status,
   input  rbas_pkg::q16_type    block_mean,
   input  logic                 restart,
   input  logic                 csr_write,
   input  rbas_pkg::blen_type   csr_data,
   output rbas_pkg::result_type result
);

   localparam int CW = $clog2(MAX_BLOCKS + 1);
   localparam logic [CW-1:0] MAX_N = CW'(MAX_BLOCKS);
   localparam int SW = rbas_pkg::SUM_W;
   localparam int DW = rbas_pkg::DIV_W;

   // configuration and accumulator state
   rbas_pkg::blen_type blen_ff;
   logic [CW-1:0]      count_ff, count_in;
   logic [SW-1:0]      sum_ff, sum_in;
   logic [63:0]        sumsq_ff, sumsq_in;
   logic               ovf_ff, ovf_in;

   // per-item working registers
   logic [31:0]         x_ff;
   logic                restart_ff;
   logic [63:0]         sq_ff;
   rbas_pkg::trials_type trials_ff;
   logic [31:0]         mean_ff, mean_in;
   logic [31:0]         absm_ff, absm_in;
   logic [63:0]         m2_ff;
   logic [63:0]         var_ff;
   logic [31:0]         unc_ff;
   rbas_pkg::result_type out_ff;

   logic [31:0]   xmag;
   logic [CW-1:0] cnt_b;
   logic [SW-1:0] sum_b;
   logic [63:0]   sumsq_b;
   logic          ovf_b;
   logic [SW:0]   sum_w;
   logic [64:0]   sumsq_w;
   logic [SW-1:0] sum_mag;
   logic [32:0]   trials_w;
   logic [63:0]   quot;
   logic          div_start, div_busy;
   logic [DW-1:0] div_dividend;
   logic [CW-1:0] div_divisor;
   logic          sqrt_busy;
   logic [31:0]   root;

   assign xmag    = x_ff[31] ? (~x_ff + 32'd1) : x_ff;
   assign sum_mag = sum_ff[SW-1] ? (~sum_ff + SW'(1)) : sum_ff;

   // restart clears before the add
   assign cnt_b   = restart_ff ? '0 : count_ff;
   assign sum_b   = restart_ff ? '0 : sum_ff;
   assign sumsq_b = restart_ff ? '0 : sumsq_ff;
   assign ovf_b   = restart_ff ? 1'b0 : ovf_ff;

   assign sum_w   = {sum_b[SW-1], sum_b} + {{(SW-31){x_ff[31]}}, x_ff};
   assign sumsq_w = {1'b0, sumsq_b} + {1'b0, sq_ff};

   // saturating accumulate, discard at the count bound
   always_comb begin
      count_in = cnt_b;
      sum_in   = sum_b;
      sumsq_in = sumsq_b;
      ovf_in   = ovf_b;
      if (cnt_b >= MAX_N) begin
         ovf_in = 1'b1;
      end else begin
         count_in = cnt_b + CW'(1);
         if (sum_w[SW] != sum_w[SW-1]) begin
            sum_in = sum_w[SW] ? rbas_pkg::SUM_MIN : rbas_pkg::SUM_MAX;
            ovf_in = 1'b1;
         end else begin
            sum_in = sum_w[SW-1:0];
         end
         if (sumsq_w[64]) begin
            sumsq_in = '1;
            ovf_in   = 1'b1;
         end else begin
            sumsq_in = sumsq_w[63:0];
         end
      end
   end

   assign trials_w = 33'(count_ff) * 33'(blen_ff);

   // rounded mean from the quotient, clamped to 32 bits
   always_comb begin
      if (sum_ff[SW-1]) begin
         absm_in = (quot > 64'(rbas_pkg::MEAN_NEG_MAG)) ? rbas_pkg::MEAN_NEG_MAG : quot[31:0];
         mean_in = ~absm_in + 32'd1;
      end else begin
         absm_in = (quot > 64'(rbas_pkg::MEAN_POS_MAX)) ? rbas_pkg::MEAN_POS_MAX : quot[31:0];
         mean_in = absm_in;
      end
   end

   // shared divider operand select
   assign div_start = cmd.mean_go | cmd.msq_go | cmd.vdiv_go;
   always_comb begin
      div_dividend = var_ff;
      div_divisor  = count_ff - CW'(1);
      if (cmd.mean_go) begin
         div_dividend = DW'(sum_mag) + DW'(count_ff >> 1);
         div_divisor  = count_ff;
      end else if (cmd.msq_go) begin
         div_dividend = sumsq_ff;
         div_divisor  = count_ff;
      end
   end

   rbas_div #(
      .NW (CW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .quotient (quot)
   );

   rbas_sqrt u_sqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.sqrt_go),
      .operand (quot),
      .busy    (sqrt_busy),
      .root    (root)
   );

   // accumulator state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         blen_ff  <= 16'd1;
         count_ff <= '0;
         sum_ff   <= '0;
         sumsq_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         if (csr_write) begin
            blen_ff <= csr_data;
         end
         if (cmd.accum) begin
            count_ff <= count_in;
            sum_ff   <= sum_in;
            sumsq_ff <= sumsq_in;
            ovf_ff   <= ovf_in;
         end
      end
   end

   // working registers, loaded step by step
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff       <= block_mean;
         restart_ff <= restart;
      end
      if (cmd.square) begin
         sq_ff <= 64'(xmag) * 64'(xmag);
      end
      if (cmd.mean_go) begin
         trials_ff <= (trials_w > 33'(rbas_pkg::TRIALS_MAX)) ? rbas_pkg::TRIALS_MAX
                                                             : trials_w[25:0];
         unc_ff    <= '0;
      end
      if (cmd.mean_take) begin
         mean_ff <= mean_in;
         absm_ff <= absm_in;
      end
      if (cmd.msq_go) begin
         m2_ff <= 64'(absm_ff) * 64'(absm_ff);
      end
      if (cmd.var_calc) begin
         var_ff <= (quot > m2_ff) ? (quot - m2_ff) : '0;
      end
      if (cmd.unc_take) begin
         unc_ff <= root;
      end
      if (cmd.out_load) begin
         out_ff.running_mean  <= mean_ff;
         out_ff.uncertainty   <= unc_ff;
         out_ff.trials_so_far <= trials_ff;
         out_ff.overflow      <= ovf_ff;
      end
   end

   assign status.div_idle  = ~div_busy;
   assign status.sqrt_idle = ~sqrt_busy;
   assign status.multi     = (count_ff > CW'(1));
   assign result           = out_ff;

endmodule

/* hdl/rbas_ctrl.sv */
// controller: sequences one item through accumulate, divide and root steps
// depends on rbas_pkg
module rbas_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  rbas_pkg::status_type status,
   output rbas_pkg::cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_SQUARE,
      S_ACCUM,
      S_MEAN_GO,
      S_MEAN_RUN,
      S_MSQ_GO,
      S_MSQ_RUN,
      S_VDIV_GO,
      S_VDIV_RUN,
      S_SQRT_RUN,
      S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // next state and command decode
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_SQUARE;
            end
         end
         S_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = S_ACCUM;
         end
         S_ACCUM: begin
            cmd.accum = 1'b1;
            state_in  = S_MEAN_GO;
         end
         S_MEAN_GO: begin
            cmd.mean_go = 1'b1;
            state_in    = S_MEAN_RUN;
         end
         S_MEAN_RUN: begin
            if (status.div_idle) begin
               cmd.mean_take = 1'b1;
               state_in      = status.multi ? S_MSQ_GO : S_DONE;
            end
         end
         S_MSQ_GO: begin
            cmd.msq_go = 1'b1;
            state_in   = S_MSQ_RUN;
         end
         S_MSQ_RUN: begin
            if (status.div_idle) begin
               cmd.var_calc = 1'b1;
               state_in     = S_VDIV_GO;
            end
         end
         S_VDIV_GO: begin
            cmd.vdiv_go = 1'b1;
            state_in    = S_VDIV_RUN;
         end
         S_VDIV_RUN: begin
            if (status.div_idle) begin
               cmd.sqrt_go = 1'b1;
               state_in    = S_SQRT_RUN;
            end
         end
         S_SQRT_RUN: begin
            if (status.sqrt_idle) begin
               cmd.unc_take = 1'b1;
               state_in     = S_DONE;
            end
         end
         S_DONE: begin
            // hand over once the output register is free or being emptied
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule
